### design/iwma_pkg.sv
// Package for the interval window max/avg block: field widths, register
// codes, reset values and the controller/datapath command and status types.
// No dependencies.
package iwma_pkg;

	localparam int CH_W      = 6;
	localparam int TIME_W    = 64;
	localparam int VAL_W     = 32;
	localparam int FREQ_W    = 32;
	localparam int ACT_W     = 7;
	localparam int MUL_W     = TIME_W + 10;
	localparam int DIV_STEPS = 32;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 72;
	localparam int M_TUSER_W = 1;

	localparam logic [FREQ_W-1:0] TICK_FREQ_RST = 32'd1000000;
	localparam logic [ACT_W-1:0]  ACTIVE_RST    = 7'd0;

	typedef enum logic {
		REG_TICK_FREQ = 1'b0,
		REG_ACTIVE    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic clear_wr;
		logic load_in;
		logic prep;
		logic conv_go;
		logic store;
		logic scan_rd;
		logic scan_acc;
		logic avg_go;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic div_done;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

### design/interval_window_max_avg.sv
// Interval window max/avg, top level: ties the controller to the datapath.
// Depends on iwma_pkg, iwma_ctrl and iwma_dp.
//
// Each request converts end_time - start_time into milliseconds (Q16.16,
// saturating), stores it in the channel's ring of SAMPLES entries and
// returns the maximum and the truncated mean of the ring's nonzero
// entries. One request is worked at a time; a finished result waits in an
// output register while the next request is taken. A valid channel goes
// through two 32-step passes of the shared one-bit-per-cycle divider and
// the scan of the ring at one sample RAM read per cycle. A rejected
// channel skips the divider and the scan. After reset a clearing pass
// writes zero to every sample and pointer entry, during which no request
// is taken; configuration writes go through at any time.
module interval_window_max_avg import iwma_pkg::*; #(
	parameter int CHANNELS = 64,
	parameter int SAMPLES  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// channel[5:0], start_time[69:6], end_time[133:70], zero pad[135:134]
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// channel_out[5:0], max_time[37:6], avg_time[69:38], zero pad[71:70]
	output logic [M_TDATA_W-1:0] m_tdata,
	// bad_channel[0]
	output logic [M_TUSER_W-1:0] m_tuser
);

	localparam int CW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int SW = $clog2(SAMPLES);

	cmd_t          cmd;
	sts_t          sts;
	logic [CW+SW-1:0] clr_addr;
	logic [SW-1:0]    scan_idx;

	assign pready = 1'b1;

	iwma_ctrl #(
		.CHANNELS (CHANNELS),
		.SAMPLES  (SAMPLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.clr_addr (clr_addr),
		.scan_idx (scan_idx)
	);

	iwma_dp #(
		.CHANNELS (CHANNELS),
		.SAMPLES  (SAMPLES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.clr_addr (clr_addr),
		.scan_idx (scan_idx)
	);

`ifndef ASSERT_OFF
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !s_tready)
		else $error("request taken during clearing pass");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.conv_go || cmd.avg_go) |-> !sts.div_busy)
		else $error("divider restarted while busy");

	a_bad_zero_stats: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[69:6] == '0))
		else $error("rejected channel carries nonzero statistics");

	a_max_ge_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[37:6] >= m_tdata[69:38]))
		else $error("mean exceeds maximum");
`endif

endmodule

### design/iwma_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module iwma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/iwma_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// Shared by the tick conversion and the mean. Depends on iwma_pkg.
module iwma_div import iwma_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] rem_init,
	input  logic [VAL_W-1:0] dividend,
	input  logic [VAL_W-1:0] divisor,
	output logic [VAL_W-1:0] quot,
	output logic             busy,
	output logic             done
);

	localparam int STEP_W = $clog2(DIV_STEPS);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  dvd_q;
	logic [VAL_W-1:0]  dsr_q;
	logic [VAL_W-1:0]  quot_q;
	logic [VAL_W:0]    trial;
	logic              ge;
	logic [VAL_W-1:0]  rem_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[VAL_W-1]};
		ge     = trial >= {1'b0, dsr_q};
		rem_nx = ge ? VAL_W'(trial - {1'b0, dsr_q}) : trial[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			dvd_q  <= {dvd_q[VAL_W-2:0], 1'b0};
			quot_q <= {quot_q[VAL_W-2:0], ge};
		end
	end

	assign quot = quot_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

### design/iwma_ctrl.sv
// Controller: sequences clearing, conversion, store, ring scan, mean and
// result handoff. Depends on iwma_pkg.
module iwma_ctrl import iwma_pkg::*; #(
	parameter int CHANNELS = 64,
	parameter int SAMPLES  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  sts_t                    sts,
	output cmd_t                    cmd,
	output logic [((CHANNELS > 1 ? $clog2(CHANNELS) : 1) + $clog2(SAMPLES))-1:0] clr_addr,
	output logic [$clog2(SAMPLES)-1:0] scan_idx
);

	localparam int CW    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int SW    = $clog2(SAMPLES);
	localparam int CNT_W = CW + SW;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_CONVGO,
		ST_CONV,
		ST_STORE,
		ST_SCAN,
		ST_AVGGO,
		ST_AVG,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             scan_end;

	assign scan_end = cnt_q == CNT_W'(SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= sts.bad ? ST_FINISH : ST_CONVGO;
				end
				ST_CONVGO: begin
					state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (sts.div_done) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_end) begin
						cnt_q   <= '0;
						state_q <= ST_AVGGO;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_AVGGO: begin
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					if (sts.div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.clear_wr = state_q == ST_CLEAR;
		cmd.load_in  = (state_q == ST_IDLE) && s_tvalid;
		cmd.prep     = (state_q == ST_PREP) && !sts.bad;
		cmd.conv_go  = state_q == ST_CONVGO;
		cmd.store    = state_q == ST_STORE;
		cmd.scan_rd  = (state_q == ST_SCAN) && (cnt_q < CNT_W'(SAMPLES));
		cmd.scan_acc = (state_q == ST_SCAN) && (cnt_q != '0);
		cmd.avg_go   = state_q == ST_AVGGO;
		cmd.out_load = (state_q == ST_FINISH) && sts.out_free;
	end

	assign s_tready = state_q == ST_IDLE;
	assign clr_addr = cnt_q;
	assign scan_idx = cnt_q[SW-1:0];

endmodule

### design/iwma_dp.sv
// Datapath: configuration registers, input capture, tick-to-ms conversion,
// sample and pointer RAMs, ring statistics and the result register.
// Depends on iwma_pkg, iwma_ram and iwma_div.
module iwma_dp import iwma_pkg::*; #(
	parameter int CHANNELS = 64,
	parameter int SAMPLES  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [((CHANNELS > 1 ? $clog2(CHANNELS) : 1) + $clog2(SAMPLES))-1:0] clr_addr,
	input  logic [$clog2(SAMPLES)-1:0] scan_idx
);

	localparam int CW    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int SW    = $clog2(SAMPLES);
	localparam int SUMW  = VAL_W + SW;
	localparam int CNTW  = SW + 1;
	localparam int SDEPTH = 1 << (CW + SW);
	localparam int PDEPTH = 1 << CW;
	localparam logic [SW-1:0] PTR_LAST = SW'(SAMPLES - 1);

	logic [FREQ_W-1:0] freq_q;
	logic [ACT_W-1:0]  active_q;
	logic [CH_W-1:0]   ch_q;
	logic [TIME_W-1:0] diff_q;
	logic              bad_q;
	logic [MUL_W-1:0]  mul_q;
	logic              sat_q;
	logic [VAL_W-1:0]  max_q;
	logic [SUMW-1:0]   sum_q;
	logic [CNTW-1:0]   count_q;
	logic              out_valid_q;
	logic [CH_W-1:0]   out_ch_q;
	logic [VAL_W-1:0]  out_max_q;
	logic [VAL_W-1:0]  out_avg_q;
	logic              out_bad_q;

	logic              cfg_wr;
	reg_idx_t          reg_idx;
	logic [CH_W-1:0]   in_ch;
	logic [TIME_W-1:0] in_start;
	logic [TIME_W-1:0] in_end;
	logic              in_bad;
	logic [FREQ_W-1:0] freq_eff;
	logic              sat_now;
	logic [CW-1:0]     ch_idx;
	logic [SW-1:0]     ptr_rd;
	logic [SW-1:0]     ptr_nx;
	logic [VAL_W-1:0]  interval;
	logic [VAL_W-1:0]  samp_rd;
	logic              div_start;
	logic [VAL_W-1:0]  div_rem;
	logic [VAL_W-1:0]  div_dvd;
	logic [VAL_W-1:0]  div_dsr;
	logic [VAL_W-1:0]  div_quot;
	logic              div_busy;
	logic              div_done;
	logic              out_free;
	logic              s_we;
	logic [CW+SW-1:0]  s_waddr;
	logic [VAL_W-1:0]  s_wdata;
	logic              p_we;
	logic [CW-1:0]     p_waddr;
	logic [SW-1:0]     p_wdata;

	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q   <= TICK_FREQ_RST;
			active_q <= ACTIVE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TICK_FREQ: freq_q   <= pwdata;
				REG_ACTIVE:    active_q <= pwdata[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TICK_FREQ: prdata = freq_q;
			REG_ACTIVE:    prdata = PDATA_W'(active_q);
			default:       prdata = '0;
		endcase
	end

	assign in_ch    = s_tdata[CH_W-1:0];
	assign in_start = s_tdata[CH_W +: TIME_W];
	assign in_end   = s_tdata[CH_W+TIME_W +: TIME_W];
	assign in_bad   = ({1'b0, in_ch} >= active_q) || (32'(in_ch) >= 32'(CHANNELS));

	assign freq_eff = (freq_q == '0) ? FREQ_W'(1) : freq_q;
	assign sat_now  = (|mul_q[MUL_W-1:48]) || (mul_q[47:16] >= freq_eff);
	assign ch_idx   = CW'(ch_q);
	assign ptr_nx   = (ptr_rd == PTR_LAST) ? '0 : ptr_rd + 1'b1;
	assign interval = sat_q ? '1 : div_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ch_q   <= in_ch;
			diff_q <= in_end - in_start;
			bad_q  <= in_bad;
		end
		if (cmd.prep) begin
			mul_q <= {diff_q, 10'b0} - {6'b0, diff_q, 4'b0} - {7'b0, diff_q, 3'b0};
		end
		if (cmd.conv_go) begin
			sat_q <= sat_now;
		end
		if (cmd.store) begin
			max_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else if (cmd.scan_acc && (samp_rd != '0)) begin
			if (samp_rd > max_q) begin
				max_q <= samp_rd;
			end
			sum_q   <= sum_q + SUMW'(samp_rd);
			count_q <= count_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_ch_q  <= ch_q;
			out_bad_q <= bad_q;
			out_max_q <= bad_q ? '0 : max_q;
			out_avg_q <= (bad_q || (count_q == '0)) ? '0 : div_quot;
		end
	end

	assign div_start = cmd.conv_go || cmd.avg_go;
	assign div_rem   = cmd.conv_go ? mul_q[47:16] : VAL_W'(sum_q[SUMW-1:VAL_W]);
	assign div_dvd   = cmd.conv_go ? {mul_q[15:0], 16'b0} : sum_q[VAL_W-1:0];
	assign div_dsr   = cmd.conv_go ? freq_eff : VAL_W'(count_q);

	iwma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quot     (div_quot),
		.busy     (div_busy),
		.done     (div_done)
	);

	assign s_we    = cmd.clear_wr || cmd.store;
	assign s_waddr = cmd.clear_wr ? clr_addr : {ch_idx, ptr_rd};
	assign s_wdata = cmd.clear_wr ? '0 : interval;

	iwma_ram #(
		.WIDTH (VAL_W),
		.DEPTH (SDEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (cmd.scan_rd),
		.raddr ({ch_idx, scan_idx}),
		.rdata (samp_rd)
	);

	assign p_we    = cmd.clear_wr || cmd.store;
	assign p_waddr = cmd.clear_wr ? clr_addr[CW-1:0] : ch_idx;
	assign p_wdata = cmd.clear_wr ? '0 : ptr_nx;

	iwma_ram #(
		.WIDTH (SW),
		.DEPTH (PDEPTH)
	) u_ptr_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (cmd.prep),
		.raddr (ch_idx),
		.rdata (ptr_rd)
	);

	assign out_free     = !out_valid_q || m_tready;
	assign sts.bad      = bad_q;
	assign sts.div_done = div_done;
	assign sts.div_busy = div_busy;
	assign sts.out_free = out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b0, out_avg_q, out_max_q, out_ch_q};
	assign m_tuser  = out_bad_q;

endmodule
